@@ src/clp_pkg.sv @@
// ============================================================================
// clp_pkg
// Shared types and codes for the cursor linked list controller and datapath.
// ============================================================================
package clp_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Operation kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef logic [4:0] t_cmd;

    // Datapath commands, one per cycle
    localparam t_cmd CMD_IDLE     = 5'd0;
    localparam t_cmd CMD_CLEAR    = 5'd1;
    localparam t_cmd CMD_LOAD     = 5'd2;
    localparam t_cmd CMD_REJECT   = 5'd3;
    localparam t_cmd CMD_START    = 5'd4;
    localparam t_cmd CMD_FRESH    = 5'd5;
    localparam t_cmd CMD_NOFREE   = 5'd6;
    localparam t_cmd CMD_UNFREE   = 5'd7;
    localparam t_cmd CMD_WSTART   = 5'd8;
    localparam t_cmd CMD_WALK     = 5'd9;
    localparam t_cmd CMD_INS_LINK = 5'd10;
    localparam t_cmd CMD_SPLICE   = 5'd11;
    localparam t_cmd CMD_VICTIM   = 5'd12;
    localparam t_cmd CMD_UNLINK   = 5'd13;
    localparam t_cmd CMD_RETURN   = 5'd14;
    localparam t_cmd CMD_PUSH     = 5'd15;
    localparam t_cmd CMD_EMIT     = 5'd16;

    // Datapath status toward the controller
    typedef struct packed {
        logic reject;      // operation fails its count or position check
        logic is_delete;
        logic steps_zero;
        logic steps_one;
        logic link_zero;   // link read data is node 0, the free-chain anchor
        logic clr_last;    // clearing pass at its final entry
        logic out_free;    // output register can take a result
    } t_dp_flags;

endpackage

@@ src/cursor_linked_list.sv @@
// ============================================================================
// cursor_linked_list
// Ordered list in a fixed node store with a free chain; insert and delete.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: i_kind
//   (insert or delete), a 1-based i_position and i_value for inserts.
//   Output channel (o_out_valid / i_out_ready) returns one item per input:
//   o_status, o_removed_value (nonzero only on a good delete) and
//   o_list_length, the element count after the operation.
//   One item is in work at a time. A rejected item goes from the check
//   state straight to the finish state; a good insert or a good delete at
//   position p first walks p - 1 links. The next item can be accepted in
//   the cycle after the result is loaded. The walk follows one link per
//   cycle through the link RAM read port.
//   After reset a clearing pass over all NODES entries rebuilds the free
//   chain in the link RAM; o_in_ready stays low until it is done.
//   The result sits in an output register. If the receiver stalls, the
//   next item is still accepted and worked; the block then holds at its
//   end until the output register is taken.
// ============================================================================
module cursor_linked_list import clp_pkg::*; #(
    parameter int NODES      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_position,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_removed_value,
    output logic [7:0]  o_list_length
);

    t_cmd      w_cmd;
    t_dp_flags w_flags;

    // Sequencer: decides the command for the datapath every cycle
    clp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_flags    (w_flags),
        .o_cmd      (w_cmd)
    );

    // Node stores, walk registers, count and the output register
    clp_datapath #(
        .NODES      (NODES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_flags         (w_flags),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_list_length   (o_list_length)
    );

    // Only one item in work: accept drops ready for the next cycle
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is in work");

    // A failed operation never returns a removed value
    a_removed_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_removed_value == 32'd0))
        else $error("removed value on a failed operation");

    // An empty-list report carries a zero length
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (o_list_length == 8'd0))
        else $error("empty status with nonzero length");

    // Emitting a result always raises the output valid
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == CMD_EMIT) |=> o_out_valid)
        else $error("result emitted but output not valid");

endmodule

@@ src/clp_ram.sv @@
// ============================================================================
// clp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module clp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/clp_datapath.sv @@
// ============================================================================
// clp_datapath
// Node stores, walk registers, element count and output register.
// ============================================================================
module clp_datapath import clp_pkg::*; #(
    parameter int NODES      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_dp_flags   o_flags,
    input  logic        i_kind,
    input  logic [7:0]  i_position,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_removed_value,
    output logic [7:0]  o_list_length
);

    localparam int LW = $clog2(NODES);
    localparam int CW = ((LW > 8) ? LW : 8) + 1;
    localparam int XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam logic [LW-1:0] HEAD = LW'(NODES - 1);
    localparam logic [LW-1:0] FREE = '0;

    // control registers
    logic [LW-1:0] r_clr;
    logic [LW-1:0] r_count;
    logic          r_o_valid;

    // payload registers
    logic          r_kind;
    logic [7:0]    r_pos;
    logic [31:0]   r_value;
    logic [1:0]    r_status;
    logic [31:0]   r_removed;
    logic [LW-1:0] r_node;
    logic [LW-1:0] r_fresh;
    logic [LW-1:0] r_victim;
    logic [7:0]    r_steps;
    logic [1:0]    r_o_status;
    logic [31:0]   r_o_removed;
    logic [7:0]    r_o_length;

    // memory ports
    logic                  lk_we;
    logic [LW-1:0]         lk_waddr;
    logic [LW-1:0]         lk_wdata;
    logic [LW-1:0]         lk_raddr;
    logic [LW-1:0]         lk_rdata;
    logic                  dt_we;
    logic [DATA_WIDTH-1:0] dt_wdata;
    logic [DATA_WIDTH-1:0] dt_rdata;

    logic [XW-1:0] w_val_x;
    logic [XW-1:0] w_rd_x;
    logic [CW-1:0] w_pos_x;
    logic [CW-1:0] w_cnt_x;
    logic [CW-1:0] w_cnt_len;
    logic          w_full;
    logic          w_empty;
    logic          w_bad_ins;
    logic          w_bad_del;
    logic [1:0]    w_reject_code;

    assign w_val_x  = XW'(r_value);
    assign dt_wdata = w_val_x[DATA_WIDTH-1:0];
    assign w_rd_x   = XW'(dt_rdata);

    assign w_pos_x   = CW'(r_pos);
    assign w_cnt_x   = CW'(r_count);
    assign w_full    = (w_cnt_x >= CW'(NODES - 2));
    assign w_empty   = (r_count == '0);
    assign w_bad_ins = (r_pos == 8'd0) || (w_pos_x > (w_cnt_x + CW'(1)));
    assign w_bad_del = (r_pos == 8'd0) || (w_pos_x > w_cnt_x);

    always_comb begin
        if (r_kind == KIND_DELETE) begin
            w_reject_code = w_empty ? ST_EMPTY : ST_BADPOS;
        end else begin
            w_reject_code = w_full ? ST_FULL : ST_BADPOS;
        end
    end

    assign o_flags.reject     = (r_kind == KIND_DELETE) ? (w_empty || w_bad_del)
                                                        : (w_full || w_bad_ins);
    assign o_flags.is_delete  = (r_kind == KIND_DELETE);
    assign o_flags.steps_zero = (r_steps == 8'd0);
    assign o_flags.steps_one  = (r_steps == 8'd1);
    assign o_flags.link_zero  = (lk_rdata == FREE);
    assign o_flags.clr_last   = (r_clr == HEAD);
    assign o_flags.out_free   = !r_o_valid || i_out_ready;

    // memory port steering
    always_comb begin
        lk_we    = 1'b0;
        lk_waddr = r_node;
        lk_wdata = lk_rdata;
        lk_raddr = r_node;
        dt_we    = 1'b0;
        case (i_cmd)
            CMD_CLEAR: begin
                lk_we    = 1'b1;
                lk_waddr = r_clr;
                lk_wdata = (r_clr == HEAD) ? FREE : r_clr + LW'(1);
            end
            CMD_START: begin
                lk_raddr = FREE;
            end
            CMD_FRESH: begin
                lk_raddr = lk_rdata;
            end
            CMD_UNFREE: begin
                lk_we    = 1'b1;
                lk_waddr = FREE;
                dt_we    = 1'b1;
            end
            CMD_WALK: begin
                lk_raddr = lk_rdata;
            end
            CMD_INS_LINK: begin
                lk_we    = 1'b1;
                lk_waddr = r_fresh;
            end
            CMD_SPLICE: begin
                lk_we    = 1'b1;
                lk_wdata = r_fresh;
            end
            CMD_VICTIM: begin
                lk_raddr = lk_rdata;
            end
            CMD_UNLINK: begin
                lk_we    = 1'b1;
                lk_raddr = FREE;
            end
            CMD_RETURN: begin
                lk_we    = 1'b1;
                lk_waddr = r_victim;
            end
            CMD_PUSH: begin
                lk_we    = 1'b1;
                lk_waddr = FREE;
                lk_wdata = r_victim;
            end
            default: begin
            end
        endcase
    end

    clp_ram #(
        .WIDTH (LW),
        .DEPTH (NODES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    clp_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NODES)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dt_we),
        .i_waddr (r_fresh),
        .i_wdata (dt_wdata),
        .i_raddr (lk_rdata),
        .o_rdata (dt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd == CMD_CLEAR) begin
                r_clr <= r_clr + LW'(1);
            end
            if (i_cmd == CMD_SPLICE) begin
                r_count <= r_count + LW'(1);
            end else if (i_cmd == CMD_PUSH) begin
                r_count <= r_count - LW'(1);
            end
            if (i_cmd == CMD_EMIT) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_kind    <= i_kind;
                r_pos     <= i_position;
                r_value   <= i_value;
                r_removed <= '0;
                r_status  <= ST_OK;
            end
            CMD_REJECT: begin
                r_status <= w_reject_code;
            end
            CMD_START: begin
                r_node  <= HEAD;
                r_steps <= r_pos - 8'd1;
            end
            CMD_FRESH: begin
                r_fresh <= lk_rdata;
            end
            CMD_NOFREE: begin
                r_status <= ST_FULL;
            end
            CMD_WALK: begin
                r_node  <= lk_rdata;
                r_steps <= r_steps - 8'd1;
            end
            CMD_VICTIM: begin
                r_victim <= lk_rdata;
            end
            CMD_UNLINK: begin
                r_removed <= w_rd_x[31:0];
            end
            CMD_EMIT: begin
                r_o_status  <= r_status;
                r_o_removed <= r_removed;
                r_o_length  <= w_cnt_len[7:0];
            end
            default: begin
            end
        endcase
    end

    assign w_cnt_len = CW'(r_count);

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_removed_value = r_o_removed;
    assign o_list_length   = r_o_length;

endmodule

@@ src/clp_ctrl.sv @@
// ============================================================================
// clp_ctrl
// Sequencer that steps the datapath through clear, check, walk, and splice or unlink.
// ============================================================================
module clp_ctrl import clp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_flags i_flags,
    output t_cmd      o_cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_IFRESH  = 4'd3;
    localparam logic [3:0] S_IFNEXT  = 4'd4;
    localparam logic [3:0] S_WSTART  = 4'd5;
    localparam logic [3:0] S_WALK    = 4'd6;
    localparam logic [3:0] S_POST    = 4'd7;
    localparam logic [3:0] S_ISPLICE = 4'd8;
    localparam logic [3:0] S_DVNEXT  = 4'd9;
    localparam logic [3:0] S_DFREE   = 4'd10;
    localparam logic [3:0] S_DPUSH   = 4'd11;
    localparam logic [3:0] S_FINISH  = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_IDLE;
        case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_flags.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_flags.reject) begin
                    o_cmd   = CMD_REJECT;
                    n_state = S_FINISH;
                end else begin
                    o_cmd   = CMD_START;
                    n_state = i_flags.is_delete ? S_WSTART : S_IFRESH;
                end
            end
            S_IFRESH: begin
                if (i_flags.link_zero) begin
                    o_cmd   = CMD_NOFREE;
                    n_state = S_FINISH;
                end else begin
                    o_cmd   = CMD_FRESH;
                    n_state = S_IFNEXT;
                end
            end
            S_IFNEXT: begin
                o_cmd   = CMD_UNFREE;
                n_state = S_WSTART;
            end
            S_WSTART: begin
                o_cmd   = CMD_WSTART;
                n_state = i_flags.steps_zero ? S_POST : S_WALK;
            end
            S_WALK: begin
                o_cmd = CMD_WALK;
                if (i_flags.steps_one) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (i_flags.is_delete) begin
                    o_cmd   = CMD_VICTIM;
                    n_state = S_DVNEXT;
                end else begin
                    o_cmd   = CMD_INS_LINK;
                    n_state = S_ISPLICE;
                end
            end
            S_ISPLICE: begin
                o_cmd   = CMD_SPLICE;
                n_state = S_FINISH;
            end
            S_DVNEXT: begin
                o_cmd   = CMD_UNLINK;
                n_state = S_DFREE;
            end
            S_DFREE: begin
                o_cmd   = CMD_RETURN;
                n_state = S_DPUSH;
            end
            S_DPUSH: begin
                o_cmd   = CMD_PUSH;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_flags.out_free) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
